>>> rtl/cacd_pkg.sv
package cacd_pkg;

  // row size and derived widths
  localparam int VALUE_LIMIT = 128;
  localparam int IDX_W = $clog2(VALUE_LIMIT);
  localparam int CNT_W = IDX_W + 1;
  localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

  // field widths
  localparam int VALUE_W = 8;
  localparam int COUNT_W = 30;
  localparam int SUM_W = COUNT_W + 2;

  // modulus and register reset
  localparam logic [COUNT_W-1:0] COUNT_MOD = COUNT_W'(1000000007);
  localparam logic [VALUE_W-1:0] MAX_VALUE_RST = VALUE_W'(100);

  localparam logic [SUM_W-1:0] MOD_X1 = SUM_W'(COUNT_MOD);
  localparam logic [SUM_W-1:0] MOD_X2 = SUM_W'(COUNT_MOD) << 1;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_LOAD   = 4'b0010,
    S_SWEEP  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  // sequencer to datapath controls
  typedef struct packed {
    logic start;
    logic load;
    logic step;
    logic first;
    logic keep;
    logic next_ok;
    logic emit;
  } ctrl_t;

  // three operand add modulo the prime, operands already reduced
  function automatic logic [COUNT_W-1:0] mod_add3(input logic [COUNT_W-1:0] x,
                                                   input logic [COUNT_W-1:0] y,
                                                   input logic [COUNT_W-1:0] z);
    logic [SUM_W-1:0] s;
    logic [SUM_W-1:0] r;
    s = SUM_W'(x) + SUM_W'(y) + SUM_W'(z);
    if (s >= MOD_X2) begin
      r = s - MOD_X2;
    end else if (s >= MOD_X1) begin
      r = s - MOD_X1;
    end else begin
      r = s;
    end
    return r[COUNT_W-1:0];
  endfunction

endpackage

>>> rtl/constrained_array_count_dp_top.sv
// Counts arrays with values 1..max_value whose neighbors differ by at most one and
// which match the fixed positions, modulo 1000000007. One input word is one array
// position (fixed_value 0 = free); the word with last set ends the array and yields
// one count word. For each word the block accepts it, primes the memory, sweeps the
// row and forms the final sum. The row of counts lives in a single-port-read memory
// swept one entry per cycle through a modular adder; a second one keeps the row sum.
// in_ready stays low until the final sum is formed. A finished count waits in an
// output register while the next array is processed; the block holds only at the end
// of a later last word if that count is still not taken. max_value may be written
// only while the block is idle and takes effect from the next word.
module constrained_array_count_dp_top import cacd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] fixed_value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COUNT_W-1:0] count
);

  ctrl_t              ctrl;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  logic [IDX_W-1:0]   wr_addr;
  logic [COUNT_W-1:0] rd_data;
  logic [COUNT_W-1:0] wr_data;

  // sequencer
  cacd_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .fixed_value (fixed_value),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .ctrl        (ctrl),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  // row of counts
  cacd_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (VALUE_LIMIT)
  ) u_row (
    .clk   (clk),
    .we    (ctrl.step),
    .waddr (wr_addr),
    .wdata (wr_data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // modular adder datapath
  cacd_dp u_dp (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ctrl),
    .rd_data (rd_data),
    .wr_data (wr_data),
    .count   (count)
  );

`ifndef ASSERT_OFF
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready right after accepting a word");

  a_start_then_load: assert property (@(posedge clk) disable iff (rst)
    ctrl.start |=> ctrl.load)
    else $error("memory prime did not follow accept");

  a_emit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    ctrl.emit |=> out_valid)
    else $error("result not presented after emit");

  a_count_reduced: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (count < COUNT_MOD))
    else $error("count not reduced modulo the prime");
`endif

endmodule

>>> rtl/cacd_ram.sv
module cacd_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/cacd_seq.sv
module cacd_seq import cacd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] fixed_value,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output ctrl_t              ctrl,
  output logic               rd_en,
  output logic [IDX_W-1:0]   rd_addr,
  output logic [IDX_W-1:0]   wr_addr
);

  state_t             state;
  state_t             state_next;
  logic [VALUE_W-1:0] max_value;
  logic [IDX_W-1:0]   k;
  logic [VALUE_W-1:0] fv;
  logic               last_q;
  logic               first_pending;

  logic               accept;
  logic               can_out;
  logic               sweep_end;
  logic [CMP_W-1:0]   m_raw;
  logic [CMP_W-1:0]   m_eff;
  logic [CMP_W-1:0]   j;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid & in_ready;

  // effective m and current value j = k + 1
  assign m_raw = CMP_W'(max_value);
  assign m_eff = (m_raw > CMP_W'(VALUE_LIMIT)) ? CMP_W'(VALUE_LIMIT) : m_raw;
  assign j     = CMP_W'(k) + CMP_W'(1);

  assign sweep_end = (k == IDX_W'(VALUE_LIMIT - 1));
  assign can_out   = !last_q || !out_valid || out_ready;

  // controls for the datapath
  always_comb begin
    ctrl.start   = accept;
    ctrl.load    = (state == S_LOAD);
    ctrl.step    = (state == S_SWEEP);
    ctrl.first   = first_pending;
    ctrl.keep    = (j <= m_eff) && ((fv == '0) || (CMP_W'(fv) == j));
    ctrl.next_ok = (j < m_eff);
    ctrl.emit    = (state == S_FINISH) && can_out && last_q;
  end

  // row memory addressing, read runs one entry ahead of the write
  always_comb begin
    rd_en   = accept | ctrl.load | ctrl.step;
    rd_addr = '0;
    if (ctrl.load) begin
      rd_addr = IDX_W'(1);
    end else if (ctrl.step) begin
      rd_addr = k + IDX_W'(2);
    end
  end
  assign wr_addr = k;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_LOAD;
      end
      S_LOAD: begin
        state_next = S_SWEEP;
      end
      S_SWEEP: begin
        if (sweep_end) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (can_out) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state, counter, item and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      max_value     <= MAX_VALUE_RST;
      k             <= '0;
      first_pending <= 1'b1;
      out_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        max_value <= cfg_wdata;
      end
      if (ctrl.load) begin
        k <= '0;
      end else if (ctrl.step) begin
        k <= k + IDX_W'(1);
      end
      if (state == S_FINISH && can_out) begin
        first_pending <= last_q;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (ctrl.emit) begin
        out_valid <= 1'b1;
      end
    end
  end

  // captured input word
  always_ff @(posedge clk) begin
    if (accept) begin
      fv     <= fixed_value;
      last_q <= last;
    end
  end

endmodule

>>> rtl/cacd_dp.sv
module cacd_dp import cacd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  ctrl_t              ctrl,
  input  logic [COUNT_W-1:0] rd_data,
  output logic [COUNT_W-1:0] wr_data,
  output logic [COUNT_W-1:0] count
);

  logic [COUNT_W-1:0] prev;
  logic [COUNT_W-1:0] cur;
  logic [COUNT_W-1:0] new_q;
  logic               new_vld;
  logic [COUNT_W-1:0] sum;
  logic [COUNT_W-1:0] sum_next;
  logic [COUNT_W-1:0] nxt;

  // rebuilt entry from the three old neighbors
  assign nxt = ctrl.next_ok ? rd_data : '0;
  always_comb begin
    wr_data = '0;
    if (ctrl.keep) begin
      wr_data = ctrl.first ? COUNT_W'(1) : mod_add3(prev, cur, nxt);
    end
  end

  // running row sum, one entry behind the sweep
  assign sum_next = new_vld ? mod_add3(sum, new_q, '0) : sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      new_vld <= 1'b0;
    end else begin
      new_vld <= ctrl.step;
    end
  end

  // window over the old row, sum and result
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      sum <= '0;
    end else begin
      sum <= sum_next;
    end
    if (ctrl.load) begin
      prev <= '0;
      cur  <= rd_data;
    end else if (ctrl.step) begin
      prev  <= cur;
      cur   <= rd_data;
      new_q <= wr_data;
    end
    if (ctrl.emit) begin
      count <= sum_next;
    end
  end

endmodule

>>> tb/cacd_checker.sv
`timescale 1ns / 100ps

module cacd_checker import cacd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [VALUE_W-1:0] cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [VALUE_W-1:0] fixed_value,
  input  logic               last,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [COUNT_W-1:0] count,
  output int                 fail_cnt,
  output int                 open_cnt,
  output int                 done_cnt
);

  localparam longint unsigned PRIME = 64'(COUNT_MOD);

  // shadow of the register and the row of prefix counts
  logic [VALUE_W-1:0] m_reg = MAX_VALUE_RST;
  logic [COUNT_W-1:0] row [VALUE_LIMIT];
  bit                 fresh = 1'b1;
  logic [COUNT_W-1:0] expected_counts [$];
  int                 n_fail = 0;
  int                 n_open = 0;
  int                 n_done = 0;

  assign fail_cnt = n_fail;
  assign open_cnt = n_open;
  assign done_cnt = n_done;

  // rebuild the row for one array position, queue the count on the last one
  task automatic rebuild_row(input logic [VALUE_W-1:0] fv, input logic lst);
    int unsigned        m_eff;
    logic [COUNT_W-1:0] prev [VALUE_LIMIT];
    longint unsigned    acc;
    longint unsigned    total;
    bit                 keep;
    m_eff = (m_reg > VALUE_LIMIT) ? VALUE_LIMIT : m_reg;
    prev = row;
    for (int j = 1; j <= VALUE_LIMIT; j++) begin
      keep = (j <= m_eff) && (fv == 0 || fv == j);
      acc = 0;
      if (keep) begin
        if (fresh) begin
          acc = 1;
        end else begin
          acc = prev[j-1];
          if (j > 1) acc += prev[j-2];
          if (j < m_eff) acc += prev[j];
          acc = acc % PRIME;
        end
      end
      row[j-1] = acc[COUNT_W-1:0];
    end
    fresh = 1'b0;
    if (lst) begin
      total = 0;
      if (fv == 0) begin
        for (int j = 1; j <= m_eff; j++) total = (total + row[j-1]) % PRIME;
      end else if (fv <= m_eff) begin
        total = row[fv-1];
      end
      expected_counts.push_back(total[COUNT_W-1:0]);
      fresh = 1'b1;
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    if (rst) begin
      m_reg = MAX_VALUE_RST;
      for (int j = 0; j < VALUE_LIMIT; j++) row[j] = '0;
      fresh = 1'b1;
      expected_counts.delete();
    end else begin
      if (cfg_we) m_reg = cfg_wdata;
      if (out_valid && out_ready) begin
        if (expected_counts.size() == 0) begin
          $error("unexpected count word %0d with nothing outstanding", count);
          n_fail++;
        end else begin
          if (count !== expected_counts[0]) begin
            $error("count mismatch: expected %0d, actual %0d", expected_counts[0], count);
            n_fail++;
          end
          void'(expected_counts.pop_front());
          n_done++;
        end
      end
      if (in_valid && in_ready) rebuild_row(fixed_value, last);
    end
    n_open = expected_counts.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import cacd_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 300;
  localparam int WORD_TARGET = 900;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [VALUE_W-1:0] cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] fixed_value = '0;
  logic               last = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [COUNT_W-1:0] count;

  int fail_cnt;
  int open_cnt;
  int done_cnt;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int n_words = 0;
  int n_arrays = 0;
  int n_writes = 0;

  constrained_array_count_dp_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fixed_value(fixed_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .count      (count)
  );

  cacd_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .fixed_value(fixed_value),
    .last       (last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .count      (count),
    .fail_cnt   (fail_cnt),
    .open_cnt   (open_cnt),
    .done_cnt   (done_cnt)
  );

  // clock
  initial begin
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    #1200000;
    $display("TEST FAILED");
    $finish;
  end

  // count receiver: random stalls, one long hold-off on request
  initial begin
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end
      out_ready = calm || ($urandom_range(99) >= 6);
    end
  end

  // offer one position word and wait for it to be taken
  task automatic send_word(input logic [VALUE_W-1:0] fv, input logic lst);
    @(negedge clk);
    in_valid = 1'b1;
    fixed_value = fv;
    last = lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_words++;
    if (lst) n_arrays++;
  endtask

  // occasional gap on the input side, of random length to land anywhere in the sweep
  task automatic sender_gap();
    if (!calm && $urandom_range(99) < 6) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 140)) @(negedge clk);
    end
  endtask

  // write max_value once the block has drained
  task automatic write_max(input logic [VALUE_W-1:0] v);
    @(negedge clk);
    in_valid = 1'b0;
    while (open_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = v;
    @(negedge clk);
    cfg_we = 1'b0;
    n_writes++;
  endtask

  // stimulus and verdict
  initial begin
    int                 phase;
    int                 quota;
    int                 sent;
    int                 m_top;
    int                 arr_left;
    int                 walk;
    int unsigned        r;
    logic [VALUE_W-1:0] m_val;
    logic [VALUE_W-1:0] fv;
    logic               lst;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset value of max_value first
    send_word(8'd0, 1'b1);
    send_word(8'd1, 1'b1);
    send_word(8'd100, 1'b1);
    send_word(8'd101, 1'b1);    // fixed above m
    send_word(8'd255, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b1);
    send_word(8'd1, 1'b0);
    sender_gap();
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd50, 1'b1);
    send_word(8'd3, 1'b0);
    send_word(8'd0, 1'b0);
    send_word(8'd5, 1'b1);
    // smallest m
    write_max(8'd1);
    send_word(8'd0, 1'b1);
    send_word(8'd0, 1'b0);
    send_word(8'd0, 1'b1);
    // m of zero allows nothing
    write_max(8'd0);
    send_word(8'd0, 1'b1);
    send_word(8'd1, 1'b1);
    // register above the row size is clamped
    write_max(8'd255);
    send_word(8'd0, 1'b0);
    send_word(8'd128, 1'b1);
    write_max(8'd128);
    send_word(8'd128, 1'b1);
    // m shrinks in the middle of an array
    write_max(8'd50);
    send_word(8'd0, 1'b0);
    write_max(8'd3);
    send_word(8'd0, 1'b1);

    // random phases of random-walk arrays with a little noise
    sent = 0;
    phase = 0;
    arr_left = 0;
    walk = 1;
    while (sent < WORD_TARGET) begin
      r = $urandom_range(99);
      if (phase == 0) m_val = 8'd128;
      else if (r < 6) m_val = 8'd0;
      else if (r < 12) m_val = 8'd255;
      else if (r < 20) m_val = 8'd1;
      else if (r < 30) m_val = 8'd128;
      else m_val = 8'($urandom_range(2, 127));
      write_max(m_val);
      m_top = (m_val > VALUE_LIMIT) ? VALUE_LIMIT : m_val;
      if (m_top < 1) m_top = 1;
      if (walk > m_top) walk = m_top;
      if (phase == 1) hold_req = 1'b1;
      calm = (phase == 3);
      quota = (phase < 2) ? 60 : $urandom_range(40, 120);
      repeat (quota) begin
        if (arr_left == 0) begin
          arr_left = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
          walk = $urandom_range(1, m_top);
        end
        walk = walk + int'($urandom_range(0, 2)) - 1;
        if (walk < 1) walk = 1;
        if (walk > m_top) walk = m_top;
        r = $urandom_range(99);
        lst = (arr_left == 1);
        if (r < 4) begin
          fv = 8'($urandom_range(0, 255));
          lst = lst || ($urandom_range(3) == 0);
        end else if (r < 36) begin
          fv = 8'(walk);
        end else begin
          fv = '0;
        end
        arr_left = lst ? 0 : arr_left - 1;
        send_word(fv, lst);
        sender_gap();
        sent++;
      end
      phase++;
    end
    calm = 1'b0;

    // drain
    @(negedge clk);
    in_valid = 1'b0;
    last = 1'b0;
    while (open_cnt != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);

    $display("run covered %0d position words in %0d arrays, %0d counts compared",
             n_words, n_arrays, done_cnt);
    $display("max_value written %0d times incl. 0, 1, 128, 255; one long output stall",
             n_writes);
    if (fail_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/cacd_pkg.sv
rtl/cacd_ram.sv
rtl/cacd_seq.sv
rtl/cacd_dp.sv
rtl/constrained_array_count_dp_top.sv
tb/cacd_checker.sv
tb/tb_top.sv
